@@ rtl/triad_attitude_solver_assert.svh @@
// assertion macros used by the checker of the attitude solver
// expects clk and arst_n in the scope where a macro is used
`ifndef TRIAD_ATTITUDE_SOLVER_ASSERT_SVH
`define TRIAD_ATTITUDE_SOLVER_ASSERT_SVH

// same-cycle implication
`define TAS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TAS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tas_pkg.sv @@
// shared types and constants of the attitude solver
// no dependencies
`default_nettype none

package tas_pkg;

	localparam int IN_WIDTH   = 32;
	localparam int FRAC_BITS  = 30;
	localparam int UNIT_W     = FRAC_BITS + 2;
	localparam int NORM_POS   = 30;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = FRAC_BITS + 1;
	localparam int NORM_LAT   = 9 + SQRT_STEPS + DIV_STEPS;
	localparam int TOTAL_LAT  = 3 * NORM_LAT + 7;
	localparam int ROT_W      = 32;

	typedef logic signed [63:0]         wide_t;
	typedef logic signed [UNIT_W-1:0]   unit_t;
	typedef logic signed [IN_WIDTH-1:0] in_t;
	typedef logic signed [ROT_W-1:0]    rot_t;

	typedef wide_t [2:0] wvec_t;
	typedef unit_t [2:0] uvec_t;
	typedef in_t   [2:0] ivec_t;

	typedef struct packed {
		uvec_t v;
		logic  zero;
	} norm_t;

	typedef struct packed {
		rot_t [8:0] rot;
		logic       deg;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/tas_norm.sv @@
// pipelined fixed-point vector normalizer: scale, square sum, isqrt, divide
// depends on tas_pkg
`default_nettype none

module tas_norm (
	input  logic           clk,
	input  logic           en,
	input  tas_pkg::wvec_t vec,
	output tas_pkg::norm_t res
);
	import tas_pkg::*;

	typedef struct packed {
		logic [63:0]      rad;
		logic [34:0]      rem;
		logic [31:0]      root;
		logic [2:0][30:0] c;
		logic [2:0]       neg;
		logic             zero;
	} sq_t;

	typedef struct packed {
		logic [2:0][31:0]          rem;
		logic [2:0][DIV_STEPS-1:0] low;
		logic [2:0][DIV_STEPS-1:0] q;
		logic [31:0]               n;
		logic [2:0]                neg;
		logic                      zero;
	} dv_t;

	logic [2:0][63:0] mag_s1, mag_s2, mag_s3;
	logic [2:0]       neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic [63:0]      max_s2;
	logic [3:0]       nz_s3;
	logic [3:0][3:0]  pos_s3;
	logic             zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic [2:0][63:0] mag_s4;
	logic [5:0]       p_s4;
	logic [2:0][30:0] c_s5, c_s6, c_s7;
	logic [2:0][61:0] sqc_s6;
	logic [63:0]      sq_s7;

	sq_t sq_in  [SQRT_STEPS];
	sq_t sq_nxt [SQRT_STEPS];
	sq_t sq_s   [SQRT_STEPS];
	dv_t dv_in  [DIV_STEPS];
	dv_t dv_nxt [DIV_STEPS];
	dv_t dv_s   [DIV_STEPS+1];
	dv_t dv_init;

	logic [63:0]      max01;
	logic [3:0]       nz_c;
	logic [3:0][3:0]  pos_c;
	logic [5:0]       p_c;
	logic [2:0][30:0] c_c;

	// magnitudes and signs
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][63];
				mag_s1[i] <= vec[i][63] ? (~vec[i] + 64'd1) : vec[i];
			end
		end
	end

	always_comb begin
		max01 = (mag_s1[1] > mag_s1[0]) ? mag_s1[1] : mag_s1[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			max_s2 <= (mag_s1[2] > max01) ? mag_s1[2] : max01;
		end
	end

	// leading one, highest set bit per 16-bit chunk
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			nz_c[k]  = |max_s2[k*16 +: 16];
			pos_c[k] = 4'd0;
			for (int j = 0; j < 16; j++) begin
				if (max_s2[k*16 + j])
					pos_c[k] = 4'(j);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			nz_s3   <= nz_c;
			pos_s3  <= pos_c;
			zero_s3 <= (max_s2 == 64'd0);
		end
	end

	always_comb begin
		p_c = 6'd0;
		for (int k = 0; k < 4; k++) begin
			if (nz_s3[k])
				p_c = {2'(k), pos_s3[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			zero_s4 <= zero_s3;
			p_s4    <= p_c;
		end
	end

	// bring the largest magnitude into [2^30, 2^31)
	always_comb begin
		logic [63:0] t;
		for (int i = 0; i < 3; i++) begin
			if (p_s4 > 6'(NORM_POS))
				t = mag_s4[i] >> (p_s4 - 6'(NORM_POS));
			else
				t = mag_s4[i] << (6'(NORM_POS) - p_s4);
			c_c[i] = t[30:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s5    <= c_c;
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				sqc_s6[i] <= c_s5[i] * c_s5[i];
			c_s6    <= c_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s7   <= {2'b00, sqc_s6[0]} + {2'b00, sqc_s6[1]} + {2'b00, sqc_s6[2]};
			c_s7    <= c_s6;
			neg_s7  <= neg_s6;
			zero_s7 <= zero_s6;
		end
	end

	// integer square root, one result bit per stage
	always_comb begin
		sq_in[0].rad  = sq_s7;
		sq_in[0].rem  = 35'd0;
		sq_in[0].root = 32'd0;
		sq_in[0].c    = c_s7;
		sq_in[0].neg  = neg_s7;
		sq_in[0].zero = zero_s7;
	end

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
		if (k > 0) begin : g_link
			assign sq_in[k] = sq_s[k-1];
		end

		always_comb begin
			logic [34:0] rem2;
			logic [34:0] trial;
			sq_nxt[k]     = sq_in[k];
			rem2          = {sq_in[k].rem[32:0], sq_in[k].rad[63:62]};
			trial         = {1'b0, sq_in[k].root, 2'b01};
			sq_nxt[k].rad = {sq_in[k].rad[61:0], 2'b00};
			if (rem2 >= trial) begin
				sq_nxt[k].rem  = rem2 - trial;
				sq_nxt[k].root = {sq_in[k].root[30:0], 1'b1};
			end else begin
				sq_nxt[k].rem  = rem2;
				sq_nxt[k].root = {sq_in[k].root[30:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				sq_s[k] <= sq_nxt[k];
		end
	end

	// dividend setup: (c << FRAC_BITS) + n/2
	always_comb begin
		logic [31:0]                 n;
		logic [31+FRAC_BITS:0]       d;
		n            = sq_s[SQRT_STEPS-1].root;
		dv_init.n    = n;
		dv_init.neg  = sq_s[SQRT_STEPS-1].neg;
		dv_init.zero = sq_s[SQRT_STEPS-1].zero;
		dv_init.rem  = '0;
		dv_init.low  = '0;
		dv_init.q    = '0;
		for (int i = 0; i < 3; i++) begin
			d = {1'b0, sq_s[SQRT_STEPS-1].c[i], {FRAC_BITS{1'b0}}}
				+ {{(FRAC_BITS+1){1'b0}}, n[31:1]};
			dv_init.rem[i] = {1'b0, d[31+FRAC_BITS:DIV_STEPS]};
			dv_init.low[i] = d[DIV_STEPS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			dv_s[0] <= dv_init;
	end

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		assign dv_in[k] = dv_s[k];

		always_comb begin
			logic [32:0] r2;
			dv_nxt[k] = dv_in[k];
			for (int i = 0; i < 3; i++) begin
				r2 = {dv_in[k].rem[i], dv_in[k].low[i][DIV_STEPS-1]};
				dv_nxt[k].low[i] = {dv_in[k].low[i][DIV_STEPS-2:0], 1'b0};
				if (r2 >= {1'b0, dv_in[k].n}) begin
					dv_nxt[k].rem[i] = 32'(r2 - {1'b0, dv_in[k].n});
					dv_nxt[k].q[i]   = {dv_in[k].q[i][DIV_STEPS-2:0], 1'b1};
				end else begin
					dv_nxt[k].rem[i] = r2[31:0];
					dv_nxt[k].q[i]   = {dv_in[k].q[i][DIV_STEPS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en)
				dv_s[k+1] <= dv_nxt[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_s[DIV_STEPS].zero)
					res.v[i] <= '0;
				else if (dv_s[DIV_STEPS].neg[i])
					res.v[i] <= -unit_t'({1'b0, dv_s[DIV_STEPS].q[i]});
				else
					res.v[i] <= unit_t'({1'b0, dv_s[DIV_STEPS].q[i]});
			end
			res.zero <= dv_s[DIV_STEPS].zero;
		end
	end

endmodule

`default_nettype wire

@@ rtl/triad_attitude_solver.sv @@
// channel   | signals                               | beat carries
// item      | item_valid, item_ready                | body_a/b, ref_a/b vectors
// result    | result_valid, result_ready            | rot_00..rot_22, degenerate
//
// one item per cycle while item_ready is high; a result passes through three
// normalizer passes in a row, each with a
// 32-stage square root and a FRAC_BITS+1 stage divider
// reset clears the valid bits, those of the output register and skid entry included
// a waiting result sits in the output register; a second one goes to the skid
// entry, and only then does the pipeline freeze and item_ready drop
// depends on tas_pkg and tas_norm
`default_nettype none

module triad_attitude_solver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic [31:0] body_a_x,
	input  logic [31:0] body_a_y,
	input  logic [31:0] body_a_z,
	input  logic [31:0] body_b_x,
	input  logic [31:0] body_b_y,
	input  logic [31:0] body_b_z,
	input  logic [31:0] ref_a_x,
	input  logic [31:0] ref_a_y,
	input  logic [31:0] ref_a_z,
	input  logic [31:0] ref_b_x,
	input  logic [31:0] ref_b_y,
	input  logic [31:0] ref_b_z,
	output logic        result_valid,
	input  logic        result_ready,
	output logic signed [31:0] rot_00,
	output logic signed [31:0] rot_01,
	output logic signed [31:0] rot_02,
	output logic signed [31:0] rot_10,
	output logic signed [31:0] rot_11,
	output logic signed [31:0] rot_12,
	output logic signed [31:0] rot_20,
	output logic signed [31:0] rot_21,
	output logic signed [31:0] rot_22,
	output logic        degenerate
);
	import tas_pkg::*;

	localparam int NXT [3] = '{1, 2, 0};
	localparam int PRV [3] = '{2, 0, 1};
	localparam wide_t HALF = wide_t'(64'd1 << (FRAC_BITS - 1));
	localparam wide_t ONE  = wide_t'(64'd1 << FRAC_BITS);

	typedef struct packed {
		ivec_t bb;
		ivec_t rb;
	} seg1_t;

	typedef struct packed {
		uvec_t [1:0] e1;
		logic        z;
	} seg2_t;

	typedef struct packed {
		uvec_t [1:0] e1;
		uvec_t [1:0] e2;
		logic        z;
	} seg3_t;

	function automatic wide_t wide_in(in_t x);
		return {{(64-IN_WIDTH){x[IN_WIDTH-1]}}, x};
	endfunction

	function automatic wide_t mul_iu(in_t a, unit_t b);
		logic signed [IN_WIDTH+UNIT_W-1:0] p;
		p = a * b;
		return {{(64-IN_WIDTH-UNIT_W){p[IN_WIDTH+UNIT_W-1]}}, p};
	endfunction

	function automatic wide_t mul_uu(unit_t a, unit_t b);
		logic signed [2*UNIT_W-1:0] p;
		p = a * b;
		return {{(64-2*UNIT_W){p[2*UNIT_W-1]}}, p};
	endfunction

	logic    en;
	logic    vld_s [TOTAL_LAT];
	wvec_t   ba_w, ra_w;
	norm_t   n1b, n1r, n2b, n2r, n3b, n3r;
	seg1_t   seg1_s [NORM_LAT];
	seg2_t   seg2_s [NORM_LAT];
	seg3_t   seg3_s [NORM_LAT];

	wide_t [1:0][2:0] xpa_s1, xpb_s1, ypa_s3, ypb_s3;
	uvec_t [1:0]      e1_s1, e1_s2, e1_s3, e1_s4, e2_s3, e2_s4;
	wvec_t [1:0]      cr_s2, cr_s4;
	logic             z_s1, z_s2, z_s3, z_s4, z_s5, z_s6;
	wide_t            mp_s5 [3][3][3];
	wide_t            ms_s6 [3][3];
	result_t          m3_s7;

	logic    out_v_q, skid_v_q;
	result_t out_q, skid_q;
	logic    push, pop;

	assign en         = !skid_v_q;
	assign item_ready = en;

	// valid bits ride alongside the data
	for (genvar k = 0; k < TOTAL_LAT; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_s[k] <= 1'b0;
			else if (en)
				vld_s[k] <= (k == 0) ? item_valid : vld_s[(k == 0) ? 0 : k-1];
		end
	end

	// first frame vectors
	assign ba_w[0] = wide_in(body_a_x[IN_WIDTH-1:0]);
	assign ba_w[1] = wide_in(body_a_y[IN_WIDTH-1:0]);
	assign ba_w[2] = wide_in(body_a_z[IN_WIDTH-1:0]);
	assign ra_w[0] = wide_in(ref_a_x[IN_WIDTH-1:0]);
	assign ra_w[1] = wide_in(ref_a_y[IN_WIDTH-1:0]);
	assign ra_w[2] = wide_in(ref_a_z[IN_WIDTH-1:0]);

	tas_norm u_n1b (.clk(clk), .en(en), .vec(ba_w), .res(n1b));
	tas_norm u_n1r (.clk(clk), .en(en), .vec(ra_w), .res(n1r));

	always_ff @(posedge clk) begin
		if (en) begin
			seg1_s[0].bb <= {body_b_z[IN_WIDTH-1:0], body_b_y[IN_WIDTH-1:0],
				body_b_x[IN_WIDTH-1:0]};
			seg1_s[0].rb <= {ref_b_z[IN_WIDTH-1:0], ref_b_y[IN_WIDTH-1:0],
				ref_b_x[IN_WIDTH-1:0]};
			seg2_s[0]    <= {e1_s2, z_s2};
			seg3_s[0]    <= {e1_s4, e2_s4, z_s4};
		end
	end

	for (genvar k = 1; k < NORM_LAT; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				seg1_s[k] <= seg1_s[k-1];
				seg2_s[k] <= seg2_s[k-1];
				seg3_s[k] <= seg3_s[k-1];
			end
		end
	end

	// second frame vector: b x e1
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				xpa_s1[0][r] <= mul_iu(seg1_s[NORM_LAT-1].bb[NXT[r]], n1b.v[PRV[r]]);
				xpb_s1[0][r] <= mul_iu(seg1_s[NORM_LAT-1].bb[PRV[r]], n1b.v[NXT[r]]);
				xpa_s1[1][r] <= mul_iu(seg1_s[NORM_LAT-1].rb[NXT[r]], n1r.v[PRV[r]]);
				xpb_s1[1][r] <= mul_iu(seg1_s[NORM_LAT-1].rb[PRV[r]], n1r.v[NXT[r]]);
			end
			e1_s1 <= {n1r.v, n1b.v};
			z_s1  <= n1b.zero | n1r.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int f = 0; f < 2; f++)
				for (int r = 0; r < 3; r++)
					cr_s2[f][r] <= xpa_s1[f][r] - xpb_s1[f][r];
			e1_s2 <= e1_s1;
			z_s2  <= z_s1;
		end
	end

	tas_norm u_n2b (.clk(clk), .en(en), .vec(cr_s2[0]), .res(n2b));
	tas_norm u_n2r (.clk(clk), .en(en), .vec(cr_s2[1]), .res(n2r));

	// third frame vector: e1 x e2
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				ypa_s3[0][r] <= mul_uu(seg2_s[NORM_LAT-1].e1[0][NXT[r]], n2b.v[PRV[r]]);
				ypb_s3[0][r] <= mul_uu(seg2_s[NORM_LAT-1].e1[0][PRV[r]], n2b.v[NXT[r]]);
				ypa_s3[1][r] <= mul_uu(seg2_s[NORM_LAT-1].e1[1][NXT[r]], n2r.v[PRV[r]]);
				ypb_s3[1][r] <= mul_uu(seg2_s[NORM_LAT-1].e1[1][PRV[r]], n2r.v[NXT[r]]);
			end
			e1_s3 <= seg2_s[NORM_LAT-1].e1;
			e2_s3 <= {n2r.v, n2b.v};
			z_s3  <= seg2_s[NORM_LAT-1].z | n2b.zero | n2r.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int f = 0; f < 2; f++)
				for (int r = 0; r < 3; r++)
					cr_s4[f][r] <= ypa_s3[f][r] - ypb_s3[f][r];
			e1_s4 <= e1_s3;
			e2_s4 <= e2_s3;
			z_s4  <= z_s3;
		end
	end

	tas_norm u_n3b (.clk(clk), .en(en), .vec(cr_s4[0]), .res(n3b));
	tas_norm u_n3r (.clk(clk), .en(en), .vec(cr_s4[1]), .res(n3r));

	// rot[i][j] = sum over k of ref_k[i] * body_k[j]
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					mp_s5[i][j][0] <= mul_uu(seg3_s[NORM_LAT-1].e1[1][i],
						seg3_s[NORM_LAT-1].e1[0][j]);
					mp_s5[i][j][1] <= mul_uu(seg3_s[NORM_LAT-1].e2[1][i],
						seg3_s[NORM_LAT-1].e2[0][j]);
					mp_s5[i][j][2] <= mul_uu(n3r.v[i], n3b.v[j]);
				end
			end
			z_s5 <= seg3_s[NORM_LAT-1].z | n3b.zero | n3r.zero;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					ms_s6[i][j] <= mp_s5[i][j][0] + mp_s5[i][j][1] + mp_s5[i][j][2] + HALF;
			z_s6 <= z_s5;
		end
	end

	// round half up was folded into the sum; floor shift then clamp
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if ((ms_s6[i][j] >>> FRAC_BITS) > ONE)
						m3_s7.rot[i*3+j] <= rot_t'(ONE);
					else if ((ms_s6[i][j] >>> FRAC_BITS) < -ONE)
						m3_s7.rot[i*3+j] <= rot_t'(-ONE);
					else
						m3_s7.rot[i*3+j] <= rot_t'(ms_s6[i][j] >>> FRAC_BITS);
				end
			end
			m3_s7.deg <= z_s6;
		end
	end

	// output register plus one skid entry
	assign push = en & vld_s[TOTAL_LAT-1];
	assign pop  = out_v_q & result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop)
				skid_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
			if (out_v_q && !pop)
				skid_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop)
				out_q <= skid_q;
		end else if (push) begin
			if (out_v_q && !pop)
				skid_q <= m3_s7;
			else
				out_q <= m3_s7;
		end
	end

	assign result_valid = out_v_q;
	assign rot_00       = out_q.rot[0];
	assign rot_01       = out_q.rot[1];
	assign rot_02       = out_q.rot[2];
	assign rot_10       = out_q.rot[3];
	assign rot_11       = out_q.rot[4];
	assign rot_12       = out_q.rot[5];
	assign rot_20       = out_q.rot[6];
	assign rot_21       = out_q.rot[7];
	assign rot_22       = out_q.rot[8];
	assign degenerate   = out_q.deg;

endmodule

`default_nettype wire

@@ rtl/tas_check.sv @@
// port-level checker for the attitude solver, bound to the top level
// depends on tas_pkg and triad_attitude_solver_assert.svh
`default_nettype none
`include "triad_attitude_solver_assert.svh"

module tas_check (
	input logic        clk,
	input logic        arst_n,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic signed [31:0] rot_00,
	input logic signed [31:0] rot_11,
	input logic signed [31:0] rot_22,
	input logic        degenerate
);
	import tas_pkg::*;

	localparam logic signed [31:0] LIM = 32'sd1 <<< FRAC_BITS;

	// input only backs up once a result is already waiting
	`TAS_ASSERT_NOW(a_ready_implies_out, !item_ready, result_valid, "input stalled with no result shown")

	`TAS_ASSERT_NOW(a_diag_range, result_valid, rot_00 <= LIM && rot_00 >= -LIM && rot_11 <= LIM && rot_11 >= -LIM && rot_22 <= LIM && rot_22 >= -LIM, "diagonal out of range")

	`TAS_ASSERT_NEXT(a_valid_holds, result_valid && !result_ready, result_valid, "result dropped while stalled")

	`TAS_ASSERT_NEXT(a_beat_stable, result_valid && !result_ready, $stable(rot_00) && $stable(rot_22) && $stable(degenerate), "result changed while stalled")

endmodule

bind triad_attitude_solver tas_check u_tas_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.rot_00       (rot_00),
	.rot_11       (rot_11),
	.rot_22       (rot_22),
	.degenerate   (degenerate)
);

`default_nettype wire
